>>> rtl/psts_pkg.sv
// Shared types, constants and helper functions for the per-service traffic statistics table.
// Used by psts_div, psts_dp, psts_ctrl and the top level. It depends on nothing else.
package psts_pkg;

  localparam int unsigned TABLE_CAPACITY_DEF = 256;
  localparam int unsigned SID_W        = 16;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned SEC_W        = 45;
  localparam int unsigned TOT_W        = 48;
  localparam int unsigned CNT_W        = 40;
  localparam int unsigned NUM_CTR      = 6;
  localparam int unsigned USEC_PER_SEC = 1000000;
  localparam int unsigned REM_W        = 14;
  localparam int unsigned IN_TDATA_W   = 112;
  localparam int unsigned OUT_TDATA_W  = 432;
  localparam int unsigned OUT_TUSER_W  = 3;

  // One table entry. Counter slot k: 0..2 upload packets, bytes, payload; 3..5 download.
  typedef struct packed {
    logic [NUM_CTR-1:0][CNT_W-1:0] cnt;
    logic [NUM_CTR-1:0][TOT_W-1:0] tot;
    logic [SEC_W-1:0]              second;
    logic [SID_W-1:0]              service;
  } psts_row_t;

  localparam int unsigned ROW_W = $bits(psts_row_t);

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2
  } psts_status_e;

  typedef struct packed {
    logic load;
    logic rd_mid;
    logic cmp_step;
    logic shift_init;
    logic rd_shift;
    logic wr_shift;
    logic wr_upd;
    logic wr_ins;
    logic out_drop;
  } psts_cmd_t;

  typedef struct packed {
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic k_at_pos;
    logic div_done;
    logic out_free;
  } psts_sts_t;

  function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {{(TOT_W-LEN_W+1){1'b0}}, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-LEN_W+1){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/psts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module psts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/psts_div.sv
// Divider of the microsecond timestamp by one million, one 16-bit quotient digit at a time.
// Depends on psts_pkg.
module psts_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psts_pkg::TIME_W-1:0]   dividend_i,
  output logic                          done_o,
  output logic [psts_pkg::SEC_W-1:0]    quotient_o
);

  // One million is 15625 shifted left by six, so the dividend is shifted right by six and
  // then divided by 15625 in four 16-bit digits. Each digit has two steps: a reciprocal
  // multiply gives the digit, then digit times 15625 is subtracted to leave the remainder.
  localparam int unsigned SHIFT  = 6;
  localparam int unsigned DIG_W  = 16;
  localparam int unsigned V_W    = psts_pkg::REM_W + DIG_W;
  localparam int unsigned MAG_W  = 31;
  localparam int unsigned MAG_SH = 44;
  localparam logic [V_W-1:0]   ODD_DIV = V_W'(psts_pkg::USEC_PER_SEC >> SHIFT);
  // Rounded-up 2^44 / 15625; the product shifted down by 44 is exact for any 30-bit value.
  localparam logic [MAG_W-1:0] MAGIC   = 31'd1125899907;

  logic                        busy_q, busy_d;
  logic                        ph_q, ph_d;
  logic [1:0]                  cnt_q, cnt_d;
  logic [psts_pkg::REM_W-1:0]  rem_q, rem_d;
  logic [psts_pkg::TIME_W-1:0] x_q, x_d;
  logic [DIG_W-1:0]            dig_q, dig_d;
  logic [3*DIG_W-1:0]          quo_q, quo_d;
  logic [V_W-1:0]              part, back, diff;
  logic [V_W+MAG_W-1:0]        prod;

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    x_d    = x_q;
    dig_d  = dig_q;
    quo_d  = quo_q;
    part   = {rem_q, x_q[psts_pkg::TIME_W-1 -: DIG_W]};
    prod   = {{MAG_W{1'b0}}, part} * {{V_W{1'b0}}, MAGIC};
    back   = {{(V_W-DIG_W){1'b0}}, dig_q} * ODD_DIV;
    diff   = part - back;
    if (start_i) begin
      busy_d = 1'b1;
      ph_d   = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = '0;
      x_d    = {{SHIFT{1'b0}}, dividend_i[psts_pkg::TIME_W-1:SHIFT]};
    end else if (busy_q) begin
      if (!ph_q) begin
        dig_d = prod[MAG_SH +: DIG_W];
        ph_d  = 1'b1;
      end else begin
        rem_d = diff[psts_pkg::REM_W-1:0];
        // The leading digit is always zero, so three digits hold the whole quotient.
        quo_d = {quo_q[2*DIG_W-1:0], dig_q};
        x_d   = {x_q[psts_pkg::TIME_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt_d = cnt_q + 1'b1;
        ph_d  = 1'b0;
        if (cnt_q == 2'd3) begin
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    x_q   <= x_d;
    dig_q <= dig_d;
    quo_q <= quo_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q[psts_pkg::SEC_W-1:0];

endmodule

>>> rtl/psts_dp.sv
// Datapath: input capture, search bounds, entry RAM, row update logic and output register.
// Depends on psts_pkg, psts_ram and psts_div.
module psts_dp #(
  parameter int unsigned TABLE_CAPACITY = psts_pkg::TABLE_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  psts_pkg::psts_cmd_t                cmd_i,
  output psts_pkg::psts_sts_t                sts_o,
  input  logic [psts_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                               in_dl_i,
  input  logic                               cfg_we_i,
  input  logic                               cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [psts_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic [psts_pkg::OUT_TUSER_W-1:0]   out_user_o
);

  localparam int unsigned AW = $clog2(TABLE_CAPACITY);
  localparam int unsigned CW = $clog2(TABLE_CAPACITY + 1);
  localparam int unsigned PAD_W = psts_pkg::OUT_TDATA_W - psts_pkg::SEC_W
                                  - psts_pkg::NUM_CTR*psts_pkg::CNT_W - 3*psts_pkg::TOT_W;

  logic [psts_pkg::SID_W-1:0] sid_q;
  logic                       dl_q;
  logic [psts_pkg::LEN_W-1:0] plen_q, pay_q;
  logic                       en_q;
  logic [CW-1:0]              lo_q, lo_d, hi_q, hi_d, k_q, k_d, used_q, used_d;
  logic [CW:0]                sum;
  logic [CW-1:0]              mid;

  logic                       div_done;
  logic [psts_pkg::SEC_W-1:0] sec;

  logic                       re, we;
  logic [AW-1:0]              raddr, waddr;
  psts_pkg::psts_row_t        rdata, wdata, upd, ins, nrow;
  logic                       emit;
  logic [psts_pkg::LEN_W-1:0] inc;

  logic                                       ov_q, ov_d;
  logic [1:0]                                 ost_q;
  logic                                       oiv_q;
  logic [psts_pkg::SEC_W-1:0]                 osec_q;
  logic [psts_pkg::NUM_CTR-1:0][psts_pkg::CNT_W-1:0] ocnt_q;
  logic [2:0][psts_pkg::TOT_W-1:0]            otot_q;
  logic                                       oload;

  psts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (in_data_i[psts_pkg::IN_TDATA_W-1 -: psts_pkg::TIME_W]),
    .done_o     (div_done),
    .quotient_o (sec)
  );

  assign sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = sum[CW:1];

  assign re    = cmd_i.rd_mid | cmd_i.rd_shift;
  assign raddr = cmd_i.rd_shift ? AW'(k_q - 1'b1) : mid[AW-1:0];
  assign we    = cmd_i.wr_shift | cmd_i.wr_upd | cmd_i.wr_ins;
  assign waddr = cmd_i.wr_shift ? k_q[AW-1:0] : lo_q[AW-1:0];

  psts_ram #(
    .WIDTH (psts_pkg::ROW_W),
    .DEPTH (TABLE_CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // New row for a hit and for an insert; only the packet's direction is incremented.
  always_comb begin
    emit = en_q && (sec != rdata.second);
    upd = rdata;
    upd.second = sec;
    if (emit) begin
      upd.cnt = '0;
    end
    ins = '0;
    ins.service = sid_q;
    ins.second  = sec;
    inc = '0;
    for (int i = 0; i < psts_pkg::NUM_CTR; i++) begin
      if ((i >= 3) == dl_q) begin
        inc = (i % 3 == 0) ? psts_pkg::LEN_W'(1) : ((i % 3 == 1) ? plen_q : pay_q);
        upd.tot[i] = psts_pkg::sat_tot(upd.tot[i], inc);
        ins.tot[i] = {{(psts_pkg::TOT_W-psts_pkg::LEN_W){1'b0}}, inc};
        if (en_q) begin
          upd.cnt[i] = psts_pkg::sat_cnt(upd.cnt[i], inc);
          ins.cnt[i] = {{(psts_pkg::CNT_W-psts_pkg::LEN_W){1'b0}}, inc};
        end
      end
    end
    nrow  = cmd_i.wr_ins ? ins : upd;
    wdata = cmd_i.wr_shift ? rdata : nrow;
  end

  always_comb begin
    lo_d   = lo_q;
    hi_d   = hi_q;
    k_d    = k_q;
    used_d = used_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = used_q;
    end
    if (cmd_i.cmp_step) begin
      if (rdata.service == sid_q) begin
        lo_d = mid;
      end else if (rdata.service < sid_q) begin
        lo_d = mid + 1'b1;
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.shift_init) begin
      k_d = used_q;
    end
    if (cmd_i.wr_shift) begin
      k_d = k_q - 1'b1;
    end
    if (cmd_i.wr_ins) begin
      used_d = used_q + 1'b1;
    end
  end

  assign oload = cmd_i.wr_upd | cmd_i.wr_ins | cmd_i.out_drop;
  always_comb begin
    ov_d = ov_q;
    if (oload) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      k_q    <= '0;
      used_q <= '0;
      en_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      k_q    <= k_d;
      used_q <= used_d;
      ov_q   <= ov_d;
      if (cfg_we_i) begin
        en_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sid_q  <= in_data_i[psts_pkg::SID_W-1:0];
      plen_q <= in_data_i[psts_pkg::SID_W +: psts_pkg::LEN_W];
      pay_q  <= in_data_i[psts_pkg::SID_W+psts_pkg::LEN_W +: psts_pkg::LEN_W];
      dl_q   <= in_dl_i;
    end
    if (oload) begin
      if (cmd_i.out_drop) begin
        ost_q  <= psts_pkg::ST_DROPPED;
        oiv_q  <= 1'b0;
        osec_q <= '0;
        ocnt_q <= '0;
        otot_q <= '0;
      end else begin
        ost_q  <= cmd_i.wr_ins ? psts_pkg::ST_INSERTED : psts_pkg::ST_UPDATED;
        oiv_q  <= cmd_i.wr_upd && emit;
        osec_q <= (cmd_i.wr_upd && emit) ? rdata.second : '0;
        ocnt_q <= (cmd_i.wr_upd && emit) ? rdata.cnt : '0;
        otot_q <= dl_q ? nrow.tot[5:3] : nrow.tot[2:0];
      end
    end
  end

  assign sts_o.lo_lt_hi = lo_q < hi_q;
  assign sts_o.hit      = rdata.service == sid_q;
  assign sts_o.full     = used_q >= CW'(TABLE_CAPACITY);
  assign sts_o.k_at_pos = k_q == lo_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o = ov_q;
  assign out_data_o  = {{PAD_W{1'b0}}, otot_q, ocnt_q, osec_q};
  assign out_user_o  = {oiv_q, ost_q};

endmodule

>>> rtl/psts_ctrl.sv
// Controller state machine: binary search, insert shift and result hand-off sequencing.
// Depends on psts_pkg.
module psts_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  psts_pkg::psts_sts_t  sts_i,
  output psts_pkg::psts_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRCH = 9'b000000010,
    S_CMP  = 9'b000000100,
    S_MISS = 9'b000001000,
    S_DROP = 9'b000010000,
    S_SHRD = 9'b000100000,
    S_SHWR = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_INS  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d = S_CMP;
        end else begin
          state_d = S_MISS;
        end
      end
      S_CMP: begin
        cmd_o.cmp_step = 1'b1;
        state_d = sts_i.hit ? S_UPD : S_SRCH;
      end
      S_MISS: begin
        if (sts_i.full) begin
          state_d = S_DROP;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d = S_SHRD;
        end
      end
      S_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.out_drop = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SHRD: begin
        if (sts_i.k_at_pos) begin
          state_d = S_INS;
        end else begin
          cmd_o.rd_shift = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        state_d = S_SHRD;
      end
      S_UPD: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.wr_upd = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_INS: begin
        if (sts_i.div_done && sts_i.out_free) begin
          cmd_o.wr_ins = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

>>> rtl/per_service_traffic_stats_table_core.sv
// Top level of the per-service traffic statistics table.
// Depends on psts_pkg, psts_ctrl and psts_dp.
//
// Usage:
//   The slave stream takes one classified packet per item; the master stream returns exactly
//   one result item per packet. The cfg channel writes the interval report enable bit and
//   is always ready; write it only while the block is idle.
//   Items are handled one at a time. The timestamp divider runs alongside the binary search,
//   which makes at most nine probes for a table of 256 entries. An update loads the result
//   once the search hits, the divider is done and the output register is free; a drop loads
//   once the search misses on a full table and the output register is free. An insert first
//   moves every later entry up one slot, each by a read and then a write, and then loads its
//   result once the divider is done and the output register is free. The block is ready for
//   the next item as soon as its result has been loaded.
//   The result sits in an output register; the next packet is accepted while it waits, and
//   the following result is held back until the receiver has taken the old one.
//   Reset empties the table (entry count to zero) and clears reporting; no clearing pass
//   is needed, as only entries below the count are ever read.
module per_service_traffic_stats_table_core #(
  parameter int unsigned TABLE_CAPACITY = psts_pkg::TABLE_CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // service_id[15:0], packet_length[31:16], payload_length[47:32], time_us[111:48]
  input  logic [psts_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // is_download[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // interval_second[44:0], interval_up_packets, up_bytes, up_payload, down_packets,
  // down_bytes, down_payload (40 each), dir_total_packets, bytes, payload (48 each), zero pad
  output logic [psts_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // status[1:0], interval_valid[2]
  output logic [psts_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i
);

  psts_pkg::psts_cmd_t cmd;
  psts_pkg::psts_sts_t sts;

  assign cfg_ready_o = 1'b1;

  psts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psts_dp #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_dl_i     (s_axis_tuser),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while another is in flight");

  // A dropped packet never carries an interval record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] == psts_pkg::ST_DROPPED) |-> !m_axis_tuser[2])
    else $error("record reported with a dropped packet");

  // Only updates of existing entries can close an interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == psts_pkg::ST_UPDATED)
    else $error("record reported without an entry update");

endmodule
